@@ rtl/rite_pkg.sv @@
// types, constants and character helpers for the read id token encoder
// shared by rite_ctrl, rite_dp and read_id_token_encoder_top; no dependencies
package rite_pkg;

  // fixed widths of the item fields and of the scalar state
  localparam int CharW  = 8;
  localparam int PosW   = 6;
  localparam int TokW   = 7;
  localparam int ValW   = 30;
  localparam int SelW   = 3;
  localparam int ErrW   = 2;
  localparam int AddrW  = 7;
  localparam logic [ValW-1:0] NumLimit = ValW'(1 << 26);

  // stream selector codes
  localparam logic [SelW-1:0] SelType  = 3'd0;
  localparam logic [SelW-1:0] SelStr   = 3'd2;
  localparam logic [SelW-1:0] SelChar  = 3'd3;
  localparam logic [SelW-1:0] SelDig   = 3'd4;
  localparam logic [SelW-1:0] SelDelta = 3'd5;

  // token type codes
  localparam logic [ValW-1:0] TypString = 30'd2;
  localparam logic [ValW-1:0] TypChar   = 30'd3;
  localparam logic [ValW-1:0] TypDigits = 30'd4;
  localparam logic [ValW-1:0] TypDelta  = 30'd5;
  localparam logic [ValW-1:0] TypMatch  = 30'd8;
  localparam logic [ValW-1:0] TypEnd    = 30'd10;

  // error codes
  localparam logic [ErrW-1:0] ErrNone = 2'd0;
  localparam logic [ErrW-1:0] ErrToks = 2'd1;
  localparam logic [ErrW-1:0] ErrLen  = 2'd2;

  // token classes
  localparam logic [2:0] ClNone   = 3'd0;
  localparam logic [2:0] ClLetter = 3'd1;
  localparam logic [2:0] ClZero   = 3'd2;
  localparam logic [2:0] ClNum    = 3'd3;
  localparam logic [2:0] ClSingle = 3'd4;

  typedef enum logic [4:0] {
    S_IDLE, S_DISP, S_EXT, S_NEWRD, S_NEWUSE, S_ENDCHK, S_CL, S_CL_AFTER,
    S_CL_STR, S_STR_LOOP, S_STR_WT, S_NUM_F, S_NUM_RD, S_NUM_STEP, S_NUM_DEC,
    S_NUM_V, S_CL_CH, S_CH_V, S_CL_FIN, S_PSRD, S_PSLD, S_END, S_COPY,
    S_COPY_WR, S_END_FIN, S_ERR, S_FLUSH
  } state_t;

  typedef enum logic [1:0] {R_OPEN, R_ENDCHK, R_END, R_FLUSH} ret_t;

  // previous-id read address select
  typedef enum logic [2:0] {PRD_NONE, PRD_EXT, PRD_PS, PRD_AFTER, PRD_DIG} prd_t;

  // result kinds
  typedef enum logic [3:0] {
    EM_ERR_TOK, EM_ERR_LEN, EM_TYPE_MATCH, EM_TYPE_STRING, EM_TYPE_CHAR,
    EM_TYPE_DIGITS, EM_TYPE_DELTA, EM_TYPE_END, EM_STR_CUR, EM_STR_ZERO,
    EM_STR_NUL, EM_CHAR, EM_DIGITS, EM_DELTA
  } em_t;

  typedef struct packed {
    logic cur_wr;
    logic ext_do;
    logic open_new;
    logic cap_open;
    logic cap_single;
    logic clr_open;
    logic after_latch;
    logic f_latch;
    logic dig_step;
    logic k_clr;
    logic k_inc;
    logic pts_rd;
    logic ps_load;
    logic pts_wr;
    logic copy_rd;
    logic str_rd;
    logic copy_wr;
    logic end_fin;
    logic new_id;
    logic set_drop;
    logic clr_drop;
    logic emit;
    logic flush;
    prd_t prd;
    em_t  em;
  } cmd_t;

  typedef struct packed {
    logic       drop;
    logic       has;
    logic       ends;
    logic       pos_full;
    logic       extend;
    logic       open;
    logic       single;
    logic       tok_full;
    logic [2:0] ccls;
    logic       full_same;
    logic       k_done;
    logic       copy_done;
    logic       nonempty;
    logic       f_ok;
    logic       dig_more;
    logic       num_match;
    logic       delta_ok;
    logic       cmatch_nz;
    logic       can_emit;
    logic       held_v;
  } sts_t;

  function automatic logic is_letter(input logic [CharW-1:0] c);
    logic [CharW-1:0] l;
    l = c | 8'h20;
    return (l >= 8'h61) && (l <= 8'h7a);
  endfunction

  function automatic logic is_dig(input logic [CharW-1:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic [2:0] char_class(input logic [CharW-1:0] c);
    logic [2:0] r;
    if (is_letter(c)) r = ClLetter;
    else if (c == 8'h30) r = ClZero;
    else if (is_dig(c)) r = ClNum;
    else r = ClNone;
    return r;
  endfunction

endpackage

@@ rtl/rite_ctrl.sv @@
// sequencer of the read id token encoder: walks each item through its steps
// depends on rite_pkg; drives rite_dp through cmd_t and reads sts_t
module rite_ctrl import rite_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_fire,
  input  sts_t sts,
  output cmd_t cmd,
  output logic in_ready
);

  state_t state, state_next;
  ret_t   ret, ret_next;

  // state and return registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ret   <= R_FLUSH;
    end else begin
      state <= state_next;
      ret   <= ret_next;
    end
  end

  // next state and commands
  always_comb begin
    cmd        = '0;
    cmd.prd    = PRD_NONE;
    cmd.em     = EM_TYPE_MATCH;
    state_next = state;
    ret_next   = ret;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_fire) state_next = S_DISP;
      end
      S_DISP: begin
        if (sts.drop) begin
          if (sts.ends) begin
            cmd.new_id   = 1'b1;
            cmd.clr_drop = 1'b1;
            ret_next     = R_FLUSH;
            state_next   = S_PSRD;
          end else begin
            state_next = S_IDLE;
          end
        end else if (sts.has) begin
          if (sts.pos_full) begin
            if (sts.can_emit) begin
              cmd.emit   = 1'b1;
              cmd.em     = EM_ERR_LEN;
              state_next = S_ERR;
            end
          end else begin
            cmd.cur_wr = 1'b1;
            if (sts.extend) begin
              cmd.prd    = PRD_EXT;
              state_next = S_EXT;
            end else if (sts.open) begin
              cmd.cap_open = 1'b1;
              cmd.clr_open = 1'b1;
              ret_next     = R_OPEN;
              state_next   = S_CL;
            end else begin
              state_next = S_NEWRD;
            end
          end
        end else begin
          state_next = S_ENDCHK;
        end
      end
      S_EXT: begin
        cmd.ext_do = 1'b1;
        state_next = S_ENDCHK;
      end
      S_NEWRD: begin
        cmd.prd    = PRD_PS;
        state_next = S_NEWUSE;
      end
      S_NEWUSE: begin
        if (sts.single) begin
          cmd.cap_single = 1'b1;
          ret_next       = R_ENDCHK;
          state_next     = S_CL;
        end else begin
          cmd.open_new = 1'b1;
          state_next   = S_ENDCHK;
        end
      end
      S_ENDCHK: begin
        if (!sts.ends) begin
          state_next = S_FLUSH;
        end else if (sts.open) begin
          cmd.cap_open = 1'b1;
          cmd.clr_open = 1'b1;
          ret_next     = R_END;
          state_next   = S_CL;
        end else begin
          state_next = S_END;
        end
      end
      // token close
      S_CL: begin
        if (sts.tok_full) begin
          if (sts.can_emit) begin
            cmd.emit   = 1'b1;
            cmd.em     = EM_ERR_TOK;
            state_next = S_ERR;
          end
        end else begin
          cmd.prd    = PRD_AFTER;
          state_next = S_CL_AFTER;
        end
      end
      S_CL_AFTER: begin
        cmd.after_latch = 1'b1;
        if (sts.ccls == ClNum) begin
          cmd.prd    = PRD_PS;
          state_next = S_NUM_F;
        end else if (sts.ccls == ClSingle) begin
          state_next = S_CL_CH;
        end else begin
          state_next = S_CL_STR;
        end
      end
      S_CL_STR: begin
        if (sts.can_emit) begin
          cmd.emit = 1'b1;
          if (sts.full_same) begin
            cmd.em     = EM_TYPE_MATCH;
            state_next = S_CL_FIN;
          end else begin
            cmd.em     = EM_TYPE_STRING;
            cmd.k_clr  = 1'b1;
            state_next = S_STR_LOOP;
          end
        end
      end
      S_STR_LOOP: begin
        if (sts.k_done) begin
          if (sts.can_emit) begin
            cmd.emit   = 1'b1;
            cmd.em     = EM_STR_NUL;
            state_next = S_CL_FIN;
          end
        end else if (sts.ccls == ClLetter) begin
          cmd.str_rd = 1'b1;
          state_next = S_STR_WT;
        end else if (sts.can_emit) begin
          cmd.emit  = 1'b1;
          cmd.em    = EM_STR_ZERO;
          cmd.k_inc = 1'b1;
        end
      end
      S_STR_WT: begin
        if (sts.can_emit) begin
          cmd.emit   = 1'b1;
          cmd.em     = EM_STR_CUR;
          cmd.k_inc  = 1'b1;
          state_next = S_STR_LOOP;
        end
      end
      S_NUM_F: begin
        cmd.f_latch = 1'b1;
        if (sts.nonempty && sts.f_ok) state_next = S_NUM_RD;
        else state_next = S_NUM_DEC;
      end
      S_NUM_RD: begin
        cmd.prd    = PRD_DIG;
        state_next = S_NUM_STEP;
      end
      S_NUM_STEP: begin
        if (sts.dig_more) begin
          cmd.dig_step = 1'b1;
          state_next   = S_NUM_RD;
        end else begin
          state_next = S_NUM_DEC;
        end
      end
      S_NUM_DEC: begin
        if (sts.can_emit) begin
          cmd.emit = 1'b1;
          if (sts.num_match) begin
            cmd.em     = EM_TYPE_MATCH;
            state_next = S_CL_FIN;
          end else begin
            cmd.em     = sts.delta_ok ? EM_TYPE_DELTA : EM_TYPE_DIGITS;
            state_next = S_NUM_V;
          end
        end
      end
      S_NUM_V: begin
        if (sts.can_emit) begin
          cmd.emit   = 1'b1;
          cmd.em     = sts.delta_ok ? EM_DELTA : EM_DIGITS;
          state_next = S_CL_FIN;
        end
      end
      S_CL_CH: begin
        if (sts.can_emit) begin
          cmd.emit = 1'b1;
          if (sts.cmatch_nz) begin
            cmd.em     = EM_TYPE_MATCH;
            state_next = S_CL_FIN;
          end else begin
            cmd.em     = EM_TYPE_CHAR;
            state_next = S_CH_V;
          end
        end
      end
      S_CH_V: begin
        if (sts.can_emit) begin
          cmd.emit   = 1'b1;
          cmd.em     = EM_CHAR;
          state_next = S_CL_FIN;
        end
      end
      S_CL_FIN: begin
        cmd.pts_wr = 1'b1;
        state_next = S_PSRD;
      end
      // reload the previous start of the current token index
      S_PSRD: begin
        cmd.pts_rd = 1'b1;
        state_next = S_PSLD;
      end
      S_PSLD: begin
        cmd.ps_load = 1'b1;
        unique case (ret)
          R_OPEN:   state_next = S_NEWRD;
          R_ENDCHK: state_next = S_ENDCHK;
          R_END:    state_next = S_END;
          R_FLUSH:  state_next = S_FLUSH;
          default:  state_next = S_FLUSH;
        endcase
      end
      // end of id: END symbol, then copy into the previous id
      S_END: begin
        if (sts.can_emit) begin
          cmd.emit   = 1'b1;
          cmd.em     = EM_TYPE_END;
          cmd.k_clr  = 1'b1;
          state_next = S_COPY;
        end
      end
      S_COPY: begin
        if (sts.copy_done) begin
          state_next = S_END_FIN;
        end else begin
          cmd.copy_rd = 1'b1;
          state_next  = S_COPY_WR;
        end
      end
      S_COPY_WR: begin
        cmd.copy_wr = 1'b1;
        cmd.k_inc   = 1'b1;
        state_next  = S_COPY;
      end
      S_END_FIN: begin
        cmd.end_fin = 1'b1;
        cmd.new_id  = 1'b1;
        ret_next    = R_FLUSH;
        state_next  = S_PSRD;
      end
      S_ERR: begin
        if (sts.ends) begin
          cmd.new_id = 1'b1;
          ret_next   = R_FLUSH;
          state_next = S_PSRD;
        end else begin
          cmd.set_drop = 1'b1;
          state_next   = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (!sts.held_v) begin
          state_next = S_IDLE;
        end else if (sts.can_emit) begin
          cmd.flush  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

@@ rtl/rite_dp.sv @@
// datapath of the read id token encoder: id stores, token state, result buffer
// depends on rite_pkg; controlled by rite_ctrl
module rite_dp import rite_pkg::*; #(
  parameter int MAX_ID_LEN = 60,
  parameter int MAX_TOKENS = 128
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_fire,
  input  logic [7:0]       in_data,
  input  logic             in_last,
  input  logic             in_empty,
  input  cmd_t             cmd,
  output sts_t             sts,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [SelW-1:0]  out_sel,
  output logic [TokW-1:0]  out_idx,
  output logic [ValW-1:0]  out_val,
  output logic             out_last,
  output logic [ErrW-1:0]  out_err
);

  localparam int Depth = MAX_ID_LEN + 1;
  localparam int Paw   = $clog2(Depth);
  localparam int Taw   = $clog2(MAX_TOKENS);

  // stores
  logic [CharW-1:0] pmem [Depth];
  logic [Depth-1:0] pvalid;
  logic [CharW-1:0] cmem [Depth];
  logic [PosW-1:0]  tmem [MAX_TOKENS];
  logic [MAX_TOKENS-1:0] tvalid;

  // latched item
  logic [CharW-1:0] ch;
  logic             lst, emp;

  // token state
  logic [TokW-1:0] tok;
  logic [PosW-1:0] pos, cpos, ostart, olen, omatch, ps, k;
  logic [2:0]      ocls;
  logic [ValW-1:0] numv, pd;
  logic            drop, nonempty;

  // closing token
  logic [2:0]       ccls;
  logic [PosW-1:0]  cstart, clen, cmatch;
  logic [CharW-1:0] cch, after;
  logic             flag;
  logic [AddrW-1:0] t;

  // read data
  logic [CharW-1:0] prv_q, cur_q;
  logic             prv_ok;
  logic [PosW-1:0]  pts_q;
  logic             pts_ok;
  logic [CharW-1:0] prd_data;

  // result buffer: held result and output register
  logic             hv;
  logic [SelW-1:0]  hsel;
  logic [TokW-1:0]  hidx;
  logic [ValW-1:0]  hval;
  logic [ErrW-1:0]  herr;
  logic             out_free;

  logic [2:0]       cls;
  logic             m;
  logic [AddrW-1:0] prd_a;
  logic [Paw-1:0]   pidx, cidx, pwidx;
  logic [Taw-1:0]   tidx;
  logic [SelW-1:0]  nsel;
  logic [ValW-1:0]  nval;
  logic [ErrW-1:0]  nerr;
  logic [ValW-1:0]  diff;
  logic [CharW-1:0] pw_data;

  assign cls      = char_class(ch);
  assign prd_data = prv_ok ? prv_q : 8'd0;
  assign m        = (ch == prd_data);
  assign diff     = numv - pd;
  assign out_free = !out_valid || out_ready;

  // previous-id read address
  always_comb begin
    case (cmd.prd)
      PRD_EXT:   prd_a = {1'b0, ps} + {1'b0, olen};
      PRD_AFTER: prd_a = {1'b0, ps} + {1'b0, clen};
      PRD_DIG:   prd_a = {1'b0, ps} + t;
      default:   prd_a = {1'b0, ps};
    endcase
  end
  assign pidx  = prd_a[Paw-1:0];
  assign cidx  = cmd.copy_rd ? k[Paw-1:0] : Paw'(cstart + k);
  assign tidx  = tok[Taw-1:0];
  assign pwidx = cmd.end_fin ? pos[Paw-1:0] : k[Paw-1:0];
  assign pw_data = cmd.end_fin ? 8'd0 : cur_q;

  // status to the sequencer
  always_comb begin
    sts.drop      = drop;
    sts.has       = !emp && (ch != 8'd0);
    sts.ends      = lst || emp;
    sts.pos_full  = 32'(pos) >= MAX_ID_LEN - 1;
    if (ocls == ClNum) sts.extend = is_dig(ch) && (numv < NumLimit);
    else sts.extend = (ocls != ClNone) && (cls == ocls);
    sts.open      = ocls != ClNone;
    sts.single    = cls == ClNone;
    sts.tok_full  = 32'(tok) + 1 > MAX_TOKENS - 2;
    sts.ccls      = ccls;
    sts.full_same = (cmatch == clen) &&
                    ((ccls == ClLetter) ? !is_letter(after) : (after != 8'h30));
    sts.k_done    = k == clen;
    sts.copy_done = k == pos;
    sts.nonempty  = nonempty;
    sts.f_ok      = is_dig(prd_data) && (prd_data != 8'h30);
    sts.dig_more  = is_dig(prd_data) && (pd < NumLimit);
    sts.num_match = flag && (cmatch == clen) && !is_dig(after);
    sts.delta_ok  = flag && nonempty && (numv > pd) && (diff < 30'd256);
    sts.cmatch_nz = cmatch != '0;
    sts.can_emit  = !hv || out_free;
    sts.held_v    = hv;
  end

  // input latch
  always_ff @(posedge clk) begin
    if (in_fire) begin
      ch  <= in_data;
      lst <= in_last;
      emp <= in_empty;
    end
  end

  // previous id store
  always_ff @(posedge clk) begin
    if (cmd.prd != PRD_NONE) begin
      prv_q  <= pmem[pidx];
      prv_ok <= (32'(prd_a) < Depth) && pvalid[pidx];
    end
    if (cmd.copy_wr || cmd.end_fin) pmem[pwidx] <= pw_data;
  end
  always_ff @(posedge clk) begin
    if (rst) pvalid <= '0;
    else if (cmd.copy_wr || cmd.end_fin) pvalid[pwidx] <= 1'b1;
  end

  // current id store
  always_ff @(posedge clk) begin
    if (cmd.cur_wr) cmem[pos[Paw-1:0]] <= ch;
    if (cmd.copy_rd || cmd.str_rd) cur_q <= cmem[cidx];
  end

  // previous token start store
  always_ff @(posedge clk) begin
    if (cmd.pts_wr) tmem[tidx] <= cstart;
    if (cmd.pts_rd) begin
      pts_q  <= tmem[tidx];
      pts_ok <= (32'(tok) < MAX_TOKENS) && tvalid[tidx];
    end
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      tvalid <= '0;
    end else if (cmd.pts_wr) begin
      tvalid[tidx] <= 1'b1;
    end else if (cmd.end_fin) begin
      for (int i = 0; i < MAX_TOKENS; i++) begin
        if (i > 32'(tok)) tvalid[i] <= 1'b0;
      end
    end
  end

  // token and position state
  always_ff @(posedge clk) begin
    if (rst) begin
      tok      <= '0;
      pos      <= '0;
      ocls     <= ClNone;
      ostart   <= '0;
      olen     <= '0;
      omatch   <= '0;
      numv     <= '0;
      ps       <= '0;
      drop     <= 1'b0;
      nonempty <= 1'b0;
    end else begin
      if (cmd.cur_wr) begin
        cpos <= pos;
        pos  <= pos + 1'b1;
      end
      if (cmd.ext_do) begin
        omatch <= omatch + PosW'(m);
        olen   <= olen + 1'b1;
        if (ocls == ClNum)
          numv <= (numv << 3) + (numv << 1) + ValW'(ch - 8'h30);
      end
      if (cmd.open_new) begin
        ocls   <= cls;
        ostart <= cpos;
        olen   <= PosW'(1);
        omatch <= PosW'(m);
        numv   <= (cls == ClNum) ? ValW'(ch - 8'h30) : '0;
      end
      if (cmd.clr_open) ocls <= ClNone;
      if (cmd.pts_wr) tok <= tok + 1'b1;
      if (cmd.ps_load) ps <= pts_ok ? pts_q : '0;
      if (cmd.end_fin) nonempty <= pos != '0;
      if (cmd.set_drop) drop <= 1'b1;
      if (cmd.clr_drop) drop <= 1'b0;
      if (cmd.new_id) begin
        tok    <= '0;
        pos    <= '0;
        ocls   <= ClNone;
        ostart <= '0;
        olen   <= '0;
        omatch <= '0;
        numv   <= '0;
      end
    end
  end

  // closing token capture and number scan
  always_ff @(posedge clk) begin
    if (cmd.cap_open) begin
      ccls   <= ocls;
      cstart <= ostart;
      clen   <= olen;
      cmatch <= omatch;
      cch    <= 8'd0;
    end
    if (cmd.cap_single) begin
      ccls   <= ClSingle;
      cstart <= cpos;
      clen   <= PosW'(1);
      cmatch <= PosW'(m);
      cch    <= ch;
    end
    if (cmd.after_latch) after <= prd_data;
    if (cmd.f_latch) begin
      flag <= !nonempty || sts.f_ok;
      pd   <= (nonempty && sts.f_ok) ? ValW'(prd_data - 8'h30) : '0;
      t    <= AddrW'(1);
    end
    if (cmd.dig_step) begin
      pd <= (pd << 3) + (pd << 1) + ValW'(prd_data - 8'h30);
      t  <= t + 1'b1;
    end
    if (cmd.k_clr) k <= '0;
    else if (cmd.k_inc) k <= k + 1'b1;
  end

  // new result fields
  always_comb begin
    nsel = SelType;
    nval = '0;
    nerr = ErrNone;
    case (cmd.em)
      EM_ERR_TOK:     nerr = ErrToks;
      EM_ERR_LEN:     nerr = ErrLen;
      EM_TYPE_MATCH:  nval = TypMatch;
      EM_TYPE_STRING: nval = TypString;
      EM_TYPE_CHAR:   nval = TypChar;
      EM_TYPE_DIGITS: nval = TypDigits;
      EM_TYPE_DELTA:  nval = TypDelta;
      EM_TYPE_END:    nval = TypEnd;
      EM_STR_CUR:  begin nsel = SelStr;   nval = ValW'(cur_q); end
      EM_STR_ZERO: begin nsel = SelStr;   nval = ValW'(8'h30); end
      EM_STR_NUL:  begin nsel = SelStr;   nval = '0;           end
      EM_CHAR:     begin nsel = SelChar;  nval = ValW'(cch);   end
      EM_DIGITS:   begin nsel = SelDig;   nval = numv;         end
      EM_DELTA:    begin nsel = SelDelta; nval = diff;         end
      default:     nval = '0;
    endcase
  end

  // held result and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      hv        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if ((cmd.emit && hv) || cmd.flush) begin
        out_valid <= 1'b1;
        out_sel   <= hsel;
        out_idx   <= hidx;
        out_val   <= hval;
        out_err   <= herr;
        out_last  <= cmd.flush;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.emit) begin
        hv   <= 1'b1;
        hsel <= nsel;
        hidx <= tok + 1'b1;
        hval <= nval;
        herr <= nerr;
      end else if (cmd.flush) begin
        hv <= 1'b0;
      end
    end
  end

endmodule

@@ rtl/read_id_token_encoder_top.sv @@
// read id token encoder: top level joining sequencer and datapath
// depends on rite_pkg, rite_ctrl and rite_dp
//
// Use: one character of a read id per input beat on s_*; s_tlast marks the
// final character, s_tuser=1 is an empty id (or ends the id in progress).
// Each beat produces zero or more result beats on m_*; m_tlast marks the
// final result of an input beat. Results are symbols MATCH, STRING (bytes
// and a NUL), CHAR, DIGITS, DELTA and END per token, or one error result.
// Flow: one beat at a time; s_tready is high only while the sequencer is
// idle. Closing a token emits its symbols, reading each letter of a string
// from the current-id store before it is emitted; a number scans the
// previous id digit by digit, and an id end copies the id into the
// previous-id store character by character. The single-port id and
// token-start memories have registered reads, one access per sequencer step.
// Reset: previous id empty, token starts zero, no token open.
// Stall: a result waits in the output register while m_tready is low; the
// sequencer holds when both the output register and its held beat are full.
module read_id_token_encoder_top import rite_pkg::*; #(
  parameter int MAX_ID_LEN = 60,
  parameter int MAX_TOKENS = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] id_char
  input  logic        s_tlast,   // last_char
  input  logic        s_tuser,   // empty_id
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [6:0] token_index, [36:7] value, rest zero
  output logic        m_tlast,   // last_of_run
  output logic [4:0]  m_tuser    // [2:0] stream_sel, [4:3] error
);

  cmd_t             cmd;
  sts_t             sts;
  logic             in_fire;
  logic [SelW-1:0]  sel;
  logic [TokW-1:0]  idx;
  logic [ValW-1:0]  val;
  logic [ErrW-1:0]  err;

  assign in_fire = s_tvalid && s_tready;

  rite_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_fire  (in_fire),
    .sts      (sts),
    .cmd      (cmd),
    .in_ready (s_tready)
  );

  rite_dp #(
    .MAX_ID_LEN (MAX_ID_LEN),
    .MAX_TOKENS (MAX_TOKENS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_fire   (in_fire),
    .in_data   (s_tdata),
    .in_last   (s_tlast),
    .in_empty  (s_tuser),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_sel   (sel),
    .out_idx   (idx),
    .out_val   (val),
    .out_last  (m_tlast),
    .out_err   (err)
  );

  // beat packing
  assign m_tdata = {3'b000, val, idx};
  assign m_tuser = {err, sel};

endmodule

@@ tb/read_id_token_encoder_checker.sv @@
`timescale 1ns / 1ps
// result checker for the read id token encoder: tracks the input and output streams,
// models tokenizing and comparison against the previous id, compares each result beat
// depends on rite_pkg for selector, type and error codes
module read_id_token_encoder_checker import rite_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,
  input  logic        s_tlast,
  input  logic        s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [39:0] m_tdata,
  input  logic        m_tlast,
  input  logic [4:0]  m_tuser,
  output int          fail_count,
  output int          pending,
  output int          result_count
);

  localparam int IdLen  = 60;
  localparam int MaxTok = 128;
  localparam int Depth  = IdLen + 1;

  typedef struct packed {
    logic [2:0]  sel;
    logic [6:0]  idx;
    logic [29:0] val;
    logic        lst;
    logic [1:0]  err;
  } symbol_t;

  symbol_t symbols_due[$];
  symbol_t beat_syms[$];

  logic [7:0] prev_id [Depth];
  logic [7:0] cur_id [Depth];
  logic [5:0] prev_start [MaxTok];
  int unsigned tok_cnt, pos, open_cls, open_start, open_len, open_match, num_val;
  bit drop;

  function automatic logic [7:0] prev_byte(int unsigned i);
    return i < Depth ? prev_id[i] : 8'd0;
  endfunction

  function automatic logic [7:0] cur_byte(int unsigned i);
    return i < Depth ? cur_id[i] : 8'd0;
  endfunction

  function automatic bit letter(logic [7:0] c);
    logic [7:0] l;
    l = c | 8'h20;
    return l >= "a" && l <= "z";
  endfunction

  function automatic bit digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic int unsigned tok_start();
    return tok_cnt < MaxTok ? prev_start[tok_cnt] : 0;
  endfunction

  task automatic push_sym(logic [2:0] sel, int unsigned idx, int unsigned val,
                          logic [1:0] err);
    symbol_t s;
    s.sel = sel; s.idx = idx[6:0]; s.val = val[29:0]; s.lst = 1'b0; s.err = err;
    if (beat_syms.size() < 64) beat_syms.insert(beat_syms.size(), s);
  endtask

  task automatic clear_id();
    tok_cnt = 0; pos = 0; open_cls = 0; open_start = 0; open_len = 0;
    open_match = 0; num_val = 0;
  endtask

  // close a token: class 1 letters, 2 zeros, 3 number, 4 single character
  task automatic close_tok(int unsigned cls, int unsigned st, int unsigned len,
                           int unsigned mt, logic [7:0] ch, output bit ok);
    int unsigned idx, ps, pd, dv, t;
    logic [7:0] after, f;
    bit full, same, flag, nonempty;
    idx = tok_cnt + 1;
    ok = 1;
    if (tok_cnt + 1 > MaxTok - 2) begin
      push_sym(SelType, idx, 0, ErrToks);
      ok = 0;
      return;
    end
    ps = tok_start();
    after = prev_byte(ps + len);
    full = mt == len;
    if (cls == 1 || cls == 2) begin
      same = (cls == 1) ? !letter(after) : after != "0";
      if (full && same) begin
        push_sym(SelType, idx, TypMatch, ErrNone);
      end else begin
        push_sym(SelType, idx, TypString, ErrNone);
        for (int k = 0; k < len; k++)
          push_sym(SelStr, idx, cls == 1 ? cur_byte(st + k) : "0", ErrNone);
        push_sym(SelStr, idx, 0, ErrNone);
      end
    end else if (cls == 3) begin
      flag = 1; nonempty = prev_id[0] != 0; pd = 0; dv = num_val;
      if (nonempty) begin
        f = prev_byte(ps);
        if (digit(f) && f != "0") pd = f - "0";
        else flag = 0;
      end
      if (flag && nonempty) begin
        t = 1;
        while (digit(prev_byte(ps + t)) && pd < (1 << 26)) begin
          pd = pd * 10 + (prev_byte(ps + t) - "0");
          t++;
        end
      end
      if (flag && full && !digit(after)) begin
        push_sym(SelType, idx, TypMatch, ErrNone);
      end else if (flag && nonempty && dv > pd && dv - pd < 256) begin
        push_sym(SelType, idx, TypDelta, ErrNone);
        push_sym(SelDelta, idx, dv - pd, ErrNone);
      end else begin
        push_sym(SelType, idx, TypDigits, ErrNone);
        push_sym(SelDig, idx, dv, ErrNone);
      end
    end else begin
      if (mt != 0) begin
        push_sym(SelType, idx, TypMatch, ErrNone);
      end else begin
        push_sym(SelType, idx, TypChar, ErrNone);
        push_sym(SelChar, idx, ch, ErrNone);
      end
    end
    prev_start[tok_cnt] = st[5:0];
    tok_cnt++;
  endtask

  // work out all result beats of one input beat
  task automatic predict_beat(logic [7:0] c, bit last, bit empty);
    bit has, ends, ok, ext;
    int unsigned p, cls, m;
    has = !empty && c != 0;
    ends = last || empty;
    ok = 1;
    beat_syms.delete();
    if (drop) begin
      if (ends) begin
        clear_id();
        drop = 0;
      end
      return;
    end
    if (has) begin
      if (pos >= IdLen - 1) begin
        push_sym(SelType, tok_cnt + 1, 0, ErrLen);
        ok = 0;
      end else begin
        p = pos;
        cls = letter(c) ? 1 : (c == "0" ? 2 : (digit(c) ? 3 : 0));
        cur_id[p] = c;
        pos++;
        if (open_cls == 3) ext = digit(c) && num_val < (1 << 26);
        else ext = open_cls != 0 && cls == open_cls;
        if (ext) begin
          if (c == prev_byte(tok_start() + open_len)) open_match++;
          open_len++;
          if (open_cls == 3) num_val = num_val * 10 + (c - "0");
        end else begin
          if (open_cls != 0) begin
            close_tok(open_cls, open_start, open_len, open_match, 0, ok);
            open_cls = 0;
          end
          if (ok) begin
            m = (c == prev_byte(tok_start())) ? 1 : 0;
            if (cls == 0) begin
              close_tok(4, p, 1, m, c, ok);
            end else begin
              open_cls = cls; open_start = p; open_len = 1; open_match = m;
              num_val = (cls == 3) ? c - "0" : 0;
            end
          end
        end
      end
    end
    if (ok && ends) begin
      if (open_cls != 0) begin
        close_tok(open_cls, open_start, open_len, open_match, 0, ok);
        open_cls = 0;
      end
      if (ok) begin
        push_sym(SelType, tok_cnt + 1, TypEnd, ErrNone);
        for (int i = 0; i < pos && i < Depth; i++) prev_id[i] = cur_id[i];
        if (pos < Depth) prev_id[pos] = 0;
        for (int i = tok_cnt + 1; i < MaxTok; i++) prev_start[i] = 0;
        clear_id();
      end
    end
    if (!ok) begin
      if (ends) clear_id();
      else drop = 1;
    end
    if (beat_syms.size() > 0) beat_syms[beat_syms.size() - 1].lst = 1'b1;
    foreach (beat_syms[i]) symbols_due.insert(symbols_due.size(), beat_syms[i]);
  endtask

  // watch both channels at each rising edge
  always @(posedge clk) begin
    symbol_t got, exp_s;
    if (rst) begin
      for (int i = 0; i < Depth; i++) begin
        prev_id[i] = 0;
        cur_id[i] = 0;
      end
      for (int i = 0; i < MaxTok; i++) prev_start[i] = 0;
      clear_id();
      drop = 0;
      symbols_due.delete();
      fail_count = 0;
      result_count = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.sel = m_tuser[2:0]; got.idx = m_tdata[6:0]; got.val = m_tdata[36:7];
        got.lst = m_tlast; got.err = m_tuser[4:3];
        result_count++;
        if (symbols_due.size() == 0) begin
          $display("%0t: unexpected result beat, expected none actual %p", $time, got);
          fail_count++;
        end else begin
          exp_s = symbols_due.pop_front();
          if (got !== exp_s) begin
            $display("%0t: result mismatch, expected %p actual %p", $time, exp_s, got);
            fail_count++;
          end
        end
      end
      if (s_tvalid && s_tready) predict_beat(s_tdata, s_tlast, s_tuser);
    end
    pending = symbols_due.size();
  end

endmodule

@@ tb/read_id_token_encoder_top_tb.sv @@
`timescale 1ns / 1ps
// testbench top for the read id token encoder: clock, reset, id stimulus and verdict
// depends on read_id_token_encoder_top and read_id_token_encoder_checker
module read_id_token_encoder_top_tb;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'd0;   // [7:0] id_char
  logic        s_tlast = 1'b0;   // last_char
  logic        s_tuser = 1'b0;   // empty_id
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;          // [6:0] token_index, [36:7] value
  logic        m_tlast;
  logic [4:0]  m_tuser;          // [2:0] stream_sel, [4:3] error
  int          fail_count, pending, result_count;
  bit          calm = 1'b0;
  int          beats_sent = 0;
  int          ids_sent = 0;

  always #6 clk = ~clk;

  read_id_token_encoder_top u_top (.*);

  read_id_token_encoder_checker u_chk (.*);

  // receiver: random stall bursts, none once calm
  initial begin
    int n;
    m_tready <= 1'b0;
    @(posedge clk iff !rst);
    forever begin
      m_tready <= 1'b1;
      n = $urandom_range(1, 30);
      repeat (n) @(posedge clk);
      if (!calm && $urandom_range(0, 1)) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end
    end
  end

  // drive one input beat and wait for its handshake
  task automatic send_char(logic [7:0] c, bit last, bit empty);
    if (!calm && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= c;
    s_tlast <= last;
    s_tuser <= empty;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    beats_sent++;
  endtask

  task automatic send_id(string s);
    if (s.len() == 0) begin
      send_char(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    end else begin
      for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1, 1'b0);
    end
    ids_sent++;
  endtask

  function automatic logic [7:0] rand_id_char();
    int k;
    k = $urandom_range(0, 9);
    if (k < 3) return 8'("A" + $urandom_range(0, 25) + ($urandom_range(0, 1) ? 32 : 0));
    if (k < 4) return "0";
    if (k < 7) return 8'("1" + $urandom_range(0, 8));
    if (k < 9) return ($urandom_range(0, 1)) ? ":" : "_";
    return 8'($urandom_range(1, 255));
  endfunction

  function automatic bit digit_c(byte c);
    return c >= "0" && c <= "9";
  endfunction

  // random id derived from the previous one so tokens often match or step
  function automatic string mutate(string base);
    string s;
    int len;
    s = "";
    if (base.len() == 0 || $urandom_range(0, 4) == 0) begin
      len = $urandom_range(1, 20);
      for (int i = 0; i < len; i++) s = {s, string'(rand_id_char())};
    end else begin
      s = base;
      for (int j = $urandom_range(0, 2); j > 0; j--) begin
        int p;
        p = $urandom_range(0, s.len() - 1);
        if (digit_c(s[p]) && s[p] != "9" && s[p] != "0") s[p] = s[p] + 1;
        else s[p] = rand_id_char();
      end
    end
    return s;
  endfunction

  initial begin
    string prev, s;
    s_tvalid <= 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed ids: matches, deltas, zero runs, big numbers, empty id
    send_id("AB:12:00x");
    send_id("AB:12:00x");
    send_id("AB:15:000y");
    send_id("");
    send_id("zz99999999999#");
    send_id("zz100000000000");
    // zero char in the middle and a char-less last beat
    send_char("Q", 1'b0, 1'b0);
    send_char(8'd0, 1'b0, 1'b0);
    send_char(8'hff, 1'b0, 1'b0);
    send_char(8'd0, 1'b1, 1'b0);
    // empty marker ends an id in progress
    send_char("a", 1'b0, 1'b0);
    send_char("7", 1'b0, 1'b1);
    // too long: 62 characters, error then drop to the end
    s = "";
    for (int i = 0; i < 62; i++) s = {s, "k"};
    send_id(s);
    // many short tokens: alternate letter and colon
    s = "";
    for (int i = 0; i < 58; i++) s = {s, (i % 2) ? ":" : "a"};
    send_id(s);
    s = "";
    for (int i = 0; i < 58; i++) s = {s, ":"};
    send_id(s);
    send_id("ab");

    // random ids
    prev = "ab";
    while (beats_sent < 350) begin
      if (beats_sent > 290) calm = 1'b1;
      if ($urandom_range(0, 15) == 0) s = "";
      else s = mutate(prev);
      send_id(s);
      if (s.len() != 0) prev = s;
    end
    s_tvalid <= 1'b0;

    calm = 1'b1;
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    $display("sent %0d beats in %0d ids, checked %0d result beats",
             beats_sent, ids_sent, result_count);
    if (fail_count == 0 && pending == 0)
      $display("read_id_token_encoder_top: match");
    else
      $display("read_id_token_encoder_top: mismatch");
    $finish;
  end

  // watchdog
  initial begin
    #20ms;
    $display("read_id_token_encoder_top: mismatch");
    $finish;
  end

endmodule
